>>> design/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg: shared types and constants of the fall detector
// Phase encoding, register indexes, threshold and classified-item types.
// ----------------------------------------------------------------------------
package afd_pkg;

	localparam int unsigned AXIS_W  = 13;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned LEVEL_W = 13;
	localparam int unsigned WIN_W   = 16;
	localparam int unsigned SQ_W    = 25;  // one squared axis, up to 4096^2
	localparam int unsigned MAG_W   = 26;  // sum of three squares, also squared level
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned CODE_W  = 3;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned WDATA_W = 16;

	localparam logic [CNT_W-1:0] FREEFALL_COUNT = CNT_W'(3);
	localparam logic [CNT_W-1:0] SILENCE_COUNT  = CNT_W'(50);
	localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

	// squared reset levels
	localparam logic [MAG_W-1:0] FREEFALL_SQ_RST  = MAG_W'(300 * 300);
	localparam logic [MAG_W-1:0] IMPACT_SQ_RST    = MAG_W'(1300 * 1300);
	localparam logic [MAG_W-1:0] REST_LOW_SQ_RST  = MAG_W'(900 * 900);
	localparam logic [MAG_W-1:0] REST_HIGH_SQ_RST = MAG_W'(1100 * 1100);

	localparam logic [WIN_W-1:0] FREEFALL_WIN_RST = WIN_W'(1000);
	localparam logic [WIN_W-1:0] IMPACT_WIN_RST   = WIN_W'(2000);
	localparam logic [WIN_W-1:0] REST_WIN_RST     = WIN_W'(7000);
	localparam logic [WIN_W-1:0] SILENCE_RST      = WIN_W'(10000);

	typedef enum logic [IDX_W-1:0] {
		REG_FREEFALL_LEVEL = 3'd0,
		REG_IMPACT_LEVEL   = 3'd1,
		REG_REST_LOW       = 3'd2,
		REG_REST_HIGH      = 3'd3,
		REG_FREEFALL_WIN   = 3'd4,
		REG_IMPACT_WIN     = 3'd5,
		REG_REST_WIN       = 3'd6,
		REG_SILENCE        = 3'd7
	} afd_reg_t;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_FREEFALL = 5'b00010,
		PH_IMPACT   = 5'b00100,
		PH_REST     = 5'b01000,
		PH_SILENCE  = 5'b10000
	} afd_phase_t;

	localparam logic [CODE_W-1:0] CODE_IDLE     = 3'd0;
	localparam logic [CODE_W-1:0] CODE_FREEFALL = 3'd1;
	localparam logic [CODE_W-1:0] CODE_IMPACT   = 3'd2;
	localparam logic [CODE_W-1:0] CODE_REST     = 3'd3;
	localparam logic [CODE_W-1:0] CODE_SILENCE  = 3'd4;

	typedef struct packed {
		logic [MAG_W-1:0] freefall_sq;
		logic [MAG_W-1:0] impact_sq;
		logic [MAG_W-1:0] rest_low_sq;
		logic [MAG_W-1:0] rest_high_sq;
	} afd_levels_t;

	typedef struct packed {
		logic [WIN_W-1:0] freefall;
		logic [WIN_W-1:0] impact;
		logic [WIN_W-1:0] rest;
		logic [WIN_W-1:0] silence;
	} afd_windows_t;

	// classified item handed from front to back
	typedef struct packed {
		logic              vibrating;
		logic              low;
		logic              hit;
		logic              rest;
		logic [TIME_W-1:0] time_ms;
	} afd_class_t;

	function automatic logic [CODE_W-1:0] phase_code(input afd_phase_t ph);
		logic [CODE_W-1:0] c;
		unique case (ph)
			PH_FREEFALL: c = CODE_FREEFALL;
			PH_IMPACT:   c = CODE_IMPACT;
			PH_REST:     c = CODE_REST;
			PH_SILENCE:  c = CODE_SILENCE;
			default:     c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

>>> design/afd_if.sv
// ----------------------------------------------------------------------------
// afd_if: stream channels of the fall detector
// Sample channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface afd_sample_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] accel_x;
	logic signed [12:0] accel_y;
	logic signed [12:0] accel_z;
	logic [31:0]        time_ms;
	logic               vibrating;

	modport source (output valid, accel_x, accel_y, accel_z, time_ms, vibrating,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, time_ms, vibrating,
		output ready);
endinterface

interface afd_result_if;
	logic       valid;
	logic       ready;
	logic       fall_detected;
	logic [2:0] phase_now;

	modport source (output valid, fall_detected, phase_now, input ready);
	modport sink (input valid, fall_detected, phase_now, output ready);
endinterface

>>> design/afd_cfg.sv
// ----------------------------------------------------------------------------
// afd_cfg: configuration registers
// Levels are squared on write so the datapath compares squared magnitudes.
// ----------------------------------------------------------------------------
module afd_cfg
	import afd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [WDATA_W-1:0] cfg_wdata,
	output afd_levels_t        levels,
	output afd_windows_t       windows
);

	logic [MAG_W-1:0] lvl_ext;
	logic [MAG_W-1:0] lvl_sq;
	afd_levels_t      levels_q;
	afd_windows_t     windows_q;

	assign lvl_ext = MAG_W'(cfg_wdata[LEVEL_W-1:0]);
	assign lvl_sq  = lvl_ext * lvl_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q.freefall_sq  <= FREEFALL_SQ_RST;
			levels_q.impact_sq    <= IMPACT_SQ_RST;
			levels_q.rest_low_sq  <= REST_LOW_SQ_RST;
			levels_q.rest_high_sq <= REST_HIGH_SQ_RST;
			windows_q.freefall    <= FREEFALL_WIN_RST;
			windows_q.impact      <= IMPACT_WIN_RST;
			windows_q.rest        <= REST_WIN_RST;
			windows_q.silence     <= SILENCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FREEFALL_LEVEL: levels_q.freefall_sq  <= lvl_sq;
				REG_IMPACT_LEVEL:   levels_q.impact_sq    <= lvl_sq;
				REG_REST_LOW:       levels_q.rest_low_sq  <= lvl_sq;
				REG_REST_HIGH:      levels_q.rest_high_sq <= lvl_sq;
				REG_FREEFALL_WIN:   windows_q.freefall    <= cfg_wdata;
				REG_IMPACT_WIN:     windows_q.impact      <= cfg_wdata;
				REG_REST_WIN:       windows_q.rest        <= cfg_wdata;
				REG_SILENCE:        windows_q.silence     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign levels  = levels_q;
	assign windows = windows_q;

endmodule

>>> design/afd_front.sv
// ----------------------------------------------------------------------------
// afd_front: sample intake and classification
// Stage 1 squares the axes, stage 2 sums them; the sum is classified
// against the squared levels as the item is pushed into the queue.
// ----------------------------------------------------------------------------
module afd_front
	import afd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	afd_sample_if.sink  sample,
	input  afd_levels_t levels,
	input  logic        q_full,
	output logic        q_push,
	output afd_class_t  q_data
);

	logic signed [2*AXIS_W-1:0] prod_x, prod_y, prod_z;
	logic                       v_s1, v_s2;
	logic                       adv_s1, adv_s2;
	logic [SQ_W-1:0]            sq_x_s1, sq_y_s1, sq_z_s1;
	logic [TIME_W-1:0]          time_s1, time_s2;
	logic                       vib_s1, vib_s2;
	logic [MAG_W-1:0]           mag_s2;

	assign prod_x = sample.accel_x * sample.accel_x;
	assign prod_y = sample.accel_y * sample.accel_y;
	assign prod_z = sample.accel_z * sample.accel_z;

	assign q_push       = v_s2 && !q_full;
	assign adv_s2       = !v_s2 || q_push;
	assign adv_s1       = !v_s1 || adv_s2;
	assign sample.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= sample.valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample.valid) begin
			sq_x_s1 <= prod_x[SQ_W-1:0];
			sq_y_s1 <= prod_y[SQ_W-1:0];
			sq_z_s1 <= prod_z[SQ_W-1:0];
			time_s1 <= sample.time_ms;
			vib_s1  <= sample.vibrating;
		end
		if (adv_s2 && v_s1) begin
			mag_s2  <= MAG_W'(sq_x_s1) + MAG_W'(sq_y_s1) + MAG_W'(sq_z_s1);
			time_s2 <= time_s1;
			vib_s2  <= vib_s1;
		end
	end

	always_comb begin
		q_data.vibrating = vib_s2;
		q_data.time_ms   = time_s2;
		q_data.low       = mag_s2 < levels.freefall_sq;
		q_data.hit       = mag_s2 > levels.impact_sq;
		q_data.rest      = (mag_s2 > levels.rest_low_sq) && (mag_s2 < levels.rest_high_sq);
	end

endmodule

>>> design/afd_queue.sv
// ----------------------------------------------------------------------------
// afd_queue: short queue between front and back
// Holds classified items so either side can stall on its own.
// ----------------------------------------------------------------------------
module afd_queue
	import afd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  afd_class_t push_data,
	output logic       full,
	input  logic       pop,
	output afd_class_t pop_data,
	output logic       empty
);

	afd_class_t       entry_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0]  count_q;

	assign full     = count_q == Q_CW'(Q_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("afd_queue: push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("afd_queue: pop from empty queue");

endmodule

>>> design/afd_back.sv
// ----------------------------------------------------------------------------
// afd_back: phase sequencer and result register
// Pops one classified item per cycle while the result can move on, steps
// the phase machine and holds the result until it is taken.
// ----------------------------------------------------------------------------
module afd_back
	import afd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  afd_windows_t  windows,
	input  logic          q_empty,
	input  afd_class_t    q_data,
	output logic          q_pop,
	afd_result_if.source  result
);

	afd_phase_t        phase_q, phase_nx;
	logic [CNT_W-1:0]  cnt_q, cnt_nx, cnt_inc, cnt_ff;
	logic [TIME_W-1:0] start_q, start_nx;
	logic [TIME_W-1:0] elapsed;
	logic [WIN_W-1:0]  win_sel;
	logic              expired;
	logic              fall_nx;
	logic              out_adv;
	logic              out_valid_q;
	logic              out_fall_q;
	logic [CODE_W-1:0] out_code_q;

	assign out_adv = !out_valid_q || result.ready;
	assign q_pop   = out_adv && !q_empty;

	assign elapsed = q_data.time_ms - start_q;
	assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign cnt_ff  = q_data.low ? cnt_inc : cnt_q;

	always_comb begin
		unique case (phase_q)
			PH_FREEFALL: win_sel = windows.freefall;
			PH_IMPACT:   win_sel = windows.impact;
			PH_REST:     win_sel = windows.rest;
			default:     win_sel = windows.silence;
		endcase
	end

	assign expired = elapsed > TIME_W'(win_sel);

	always_comb begin
		phase_nx = phase_q;
		cnt_nx   = cnt_q;
		start_nx = start_q;
		fall_nx  = 1'b0;
		if (!q_data.vibrating) begin
			unique case (phase_q)
				PH_FREEFALL: begin
					if (expired) begin
						phase_nx = PH_IDLE;
					end else begin
						if (!q_data.low) phase_nx = PH_IDLE;
						if (cnt_ff > FREEFALL_COUNT) begin
							cnt_nx   = '0;
							phase_nx = PH_IMPACT;
						end else begin
							cnt_nx = cnt_ff;
						end
					end
				end
				PH_IMPACT: begin
					if (expired)         phase_nx = PH_IDLE;
					else if (q_data.hit) phase_nx = PH_REST;
				end
				PH_REST: begin
					if (expired) begin
						phase_nx = PH_IDLE;
					end else if (q_data.rest) begin
						phase_nx = PH_SILENCE;
						cnt_nx   = CNT_W'(1);
					end
				end
				PH_SILENCE: begin
					if (q_data.rest) begin
						cnt_nx = cnt_inc;
						if (expired || cnt_inc > SILENCE_COUNT) begin
							phase_nx = PH_IDLE;
							fall_nx  = 1'b1;
						end
					end else begin
						start_nx = q_data.time_ms;
						phase_nx = PH_REST;
					end
				end
				default: begin
					// idle, and any stray encoding behaves as idle
					if (q_data.low) begin
						start_nx = q_data.time_ms;
						phase_nx = PH_FREEFALL;
						cnt_nx   = CNT_W'(1);
					end else begin
						phase_nx = PH_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_nx;
				cnt_q   <= cnt_nx;
				start_q <= start_nx;
			end
			if (out_adv) out_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_fall_q <= fall_nx;
			out_code_q <= phase_code(phase_nx);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.fall_detected = out_fall_q;
	assign result.phase_now     = out_code_q;

	// a confirmed fall always returns the machine to idle
	a_fall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_fall_q |-> out_code_q == CODE_IDLE)
		else $error("afd_back: fall reported outside idle");

	// an item taken while vibrating leaves the state alone
	a_vib_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_data.vibrating |=> $stable(phase_q) && $stable(cnt_q) && $stable(start_q))
		else $error("afd_back: vibrating item changed state");

	// a stalled result is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> out_valid_q && $stable(out_fall_q)
			&& $stable(out_code_q))
		else $error("afd_back: pending result lost");

endmodule

>>> design/accel_fall_detector_core.sv
// ----------------------------------------------------------------------------
// accel_fall_detector_core: accelerometer fall detector
// Threshold free fall / impact / rest detection on squared magnitude.
// ----------------------------------------------------------------------------
// One result item for every sample item, in order. The block sustains one
// sample per clock while results are taken: the front squares and sums the
// axes in two stages, a four-entry queue decouples it from the back, and the
// back steps the phase machine once per item into a result register. An
// accepted sample passes the stage 1 and stage 2 registers, the queue and the
// result register. Levels are squared as they are written, so registers must
// be written only while no item is in flight.
module accel_fall_detector_core
	import afd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [WDATA_W-1:0] cfg_wdata,
	afd_sample_if.sink         sample,
	afd_result_if.source       result
);

	afd_levels_t  levels;
	afd_windows_t windows;
	logic         q_push, q_pop, q_full, q_empty;
	afd_class_t   q_wdata, q_rdata;

	afd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.levels    (levels),
		.windows   (windows)
	);

	afd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.levels (levels),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	afd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	afd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.windows (windows),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule
